/* src/boc_pkg.sv */
// ----------------------------------------------------------------------------
// boc_pkg: shared types and constants for the broadcast offset calculator
// holds the shape bundle, result bundle, register indexes and dimension lookup
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package boc_pkg;

	localparam int POS_BITS  = 31;
	localparam int CNT_BITS  = 5;
	localparam int SLOTS     = 8;
	localparam int SLOT_BITS = 16;
	localparam int IDX_BITS  = 3;
	localparam int REG_BITS  = 64;
	localparam int RANK_BITS = 4;
	localparam int CFG_IDX_BITS = 3;

	// register indexes on the config port
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_RANK      = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IN_RANK       = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_DIMS_LOW  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_OUT_DIMS_HIGH = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_IN_DIMS_LOW   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_IN_DIMS_HIGH  = 3'd5;

	// every slot holds a dimension of 1 after reset
	localparam logic [REG_BITS-1:0] DIMS_RESET = 64'h0001_0001_0001_0001;
	localparam logic [RANK_BITS-1:0] RANK_RESET = 4'd1;

	typedef logic [SLOTS-1:0][SLOT_BITS-1:0] dims_t;

	typedef struct packed {
		logic [RANK_BITS-1:0] out_rank;
		logic [RANK_BITS-1:0] in_rank;
		dims_t                out_dims;
		dims_t                in_dims;
	} shape_t;

	typedef struct packed {
		logic [POS_BITS-1:0] in_position;
		logic                shape_error;
	} res_t;

	function automatic logic [SLOT_BITS-1:0] dim_of(input dims_t dims,
			input logic [IDX_BITS-1:0] k);
		return dims[k];
	endfunction

	// zero reads as one, anything above the limit saturates
	function automatic logic [RANK_BITS-1:0] clamp_rank(input logic [RANK_BITS-1:0] r,
			input logic [RANK_BITS-1:0] max_r);
		logic [RANK_BITS-1:0] v;
		v = r;
		if (r == '0)
			v = 4'd1;
		else if (r > max_r)
			v = max_r;
		return v;
	endfunction

endpackage

`default_nettype wire

/* src/boc_div.sv */
// ----------------------------------------------------------------------------
// boc_div: radix-2 restoring divider
// one quotient bit per cycle, 31-bit dividend by a DIM_BITS-wide divisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module boc_div #(
	parameter int DIM_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [boc_pkg::POS_BITS-1:0]  dividend,
	input  wire logic [DIM_BITS-1:0]           divisor,
	output logic                               done,
	output logic [boc_pkg::POS_BITS-1:0]       quotient,
	output logic [DIM_BITS-1:0]                remainder
);

	logic [boc_pkg::POS_BITS-1:0] quo_q;
	logic [DIM_BITS-1:0]          rem_q;
	logic [DIM_BITS-1:0]          dvs_q;
	logic [boc_pkg::CNT_BITS-1:0] cnt_q;
	logic                         busy_q;
	logic                         done_q;

	logic [DIM_BITS:0]   trial;
	logic                take;
	logic [DIM_BITS-1:0] rem_nxt;

	assign trial   = {rem_q, quo_q[boc_pkg::POS_BITS-1]};
	assign take    = trial >= {1'b0, dvs_q};
	assign rem_nxt = take ? DIM_BITS'(trial - {1'b0, dvs_q}) : trial[DIM_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= boc_pkg::CNT_BITS'(boc_pkg::POS_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == boc_pkg::CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[boc_pkg::POS_BITS-2:0], take};
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

/* src/boc_ctrl.sv */
// ----------------------------------------------------------------------------
// boc_ctrl: sequencer for the offset mapping
// splits the position over the aligned dims, then rebuilds the input offset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module boc_ctrl #(
	parameter int MAX_DIMS = 8,
	parameter int DIM_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire boc_pkg::shape_t               shape,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [boc_pkg::POS_BITS-1:0]  in_pos,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output boc_pkg::res_t                      res,
	output logic                               div_start,
	output logic [boc_pkg::POS_BITS-1:0]       div_dividend,
	output logic [DIM_BITS-1:0]                div_divisor,
	input  wire logic                          div_done,
	input  wire logic [boc_pkg::POS_BITS-1:0]  div_quo,
	input  wire logic [DIM_BITS-1:0]           div_rem
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_WAIT = 5'b00100,
		ST_MAC  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	localparam logic [boc_pkg::SLOT_BITS-1:0] DimMask =
		boc_pkg::SLOT_BITS'((32'd1 << DIM_BITS) - 32'd1);

	state_t                        state_q;
	logic [boc_pkg::IDX_BITS-1:0]  i_q;
	logic [boc_pkg::POS_BITS-1:0]  pos_q;
	logic [boc_pkg::POS_BITS-1:0]  acc_q;
	logic                          err_q;
	logic [DIM_BITS-1:0]           idx_q [boc_pkg::SLOTS];

	logic [boc_pkg::RANK_BITS-1:0] orank, irank, skip;
	logic [boc_pkg::IDX_BITS-1:0]  k_out, last_i;
	logic [boc_pkg::SLOT_BITS-1:0] od, id;
	logic                          rank_err;
	logic                          od_zero;
	logic [boc_pkg::POS_BITS+boc_pkg::SLOT_BITS-1:0] prod;
	logic [boc_pkg::POS_BITS-1:0]  acc_nxt;
	logic                          step_div;

	assign orank    = boc_pkg::clamp_rank(shape.out_rank, boc_pkg::RANK_BITS'(MAX_DIMS));
	assign irank    = boc_pkg::clamp_rank(shape.in_rank, boc_pkg::RANK_BITS'(MAX_DIMS));
	assign rank_err = irank > orank;
	assign skip     = orank - irank;
	assign k_out    = boc_pkg::IDX_BITS'(skip + {1'b0, i_q});
	assign last_i   = boc_pkg::IDX_BITS'(irank - 4'd1);

	assign od      = boc_pkg::dim_of(shape.out_dims, k_out) & DimMask;
	assign id      = boc_pkg::dim_of(shape.in_dims, i_q) & DimMask;
	assign od_zero = (od == '0);

	// horner step, wraps at the position width
	assign prod    = acc_q * id;
	assign acc_nxt = prod[boc_pkg::POS_BITS-1:0]
		+ ((id != boc_pkg::SLOT_BITS'(1)) ? boc_pkg::POS_BITS'(idx_q[i_q]) : '0);

	// one dimension finished in this cycle
	assign step_div = ((state_q == ST_DIV) && od_zero) || ((state_q == ST_WAIT) && div_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						i_q     <= last_i;
						state_q <= rank_err ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV, ST_WAIT: begin
					if (step_div) begin
						if (i_q == '0) begin
							state_q <= ST_MAC;
						end else begin
							i_q     <= i_q - 1'b1;
							state_q <= ST_DIV;
						end
					end else if (state_q == ST_DIV) begin
						state_q <= ST_WAIT;
					end
				end
				ST_MAC: begin
					if (i_q == last_i)
						state_q <= ST_DONE;
					else
						i_q <= i_q + 1'b1;
				end
				ST_DONE: begin
					if (res_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			pos_q <= in_pos;
			acc_q <= '0;
			err_q <= rank_err;
		end
		if ((state_q == ST_DIV) && od_zero)
			idx_q[i_q] <= '0;
		if ((state_q == ST_WAIT) && div_done) begin
			idx_q[i_q] <= div_rem;
			pos_q      <= div_quo;
		end
		if (state_q == ST_MAC) begin
			acc_q <= acc_nxt;
			err_q <= err_q | (id > od);
		end
	end

	assign in_ready        = (state_q == ST_IDLE);
	assign res_valid       = (state_q == ST_DONE);
	assign res.in_position = acc_q;
	assign res.shape_error = err_q;

	assign div_start    = (state_q == ST_DIV) && !od_zero;
	assign div_dividend = pos_q;
	assign div_divisor  = od[DIM_BITS-1:0];

endmodule

`default_nettype wire

/* src/broadcast_offset_calc_top.sv */
// ----------------------------------------------------------------------------
// broadcast_offset_calc_top: broadcast output offset to input offset mapper
// config registers, sequencer, shared serial divider and output register
// ----------------------------------------------------------------------------
// sequence: per aligned input dimension a divider issue, one step per quotient
//   bit and a capture; a zero output dimension skips the divider; then in_rank
//   horner steps and the result handoff
// throughput: one item at a time; the sequencer takes a new item only when idle
// reset: async active low, ranks and every dimension return to 1
`timescale 1ns / 1ps
`default_nettype none

module broadcast_offset_calc_top #(
	parameter int MAX_DIMS = 8,
	parameter int DIM_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// config write port
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	// input items
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [30:0] out_position, [31] zero
	// result items
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [30:0] in_position, [31] zero
	output logic             m_axis_tuser   // [0] shape_error
);

	// configuration registers
	logic [boc_pkg::RANK_BITS-1:0] out_rank_q, in_rank_q;
	logic [boc_pkg::REG_BITS-1:0]  out_dims_low_q, out_dims_high_q;
	logic [boc_pkg::REG_BITS-1:0]  in_dims_low_q, in_dims_high_q;

	boc_pkg::shape_t shape;
	boc_pkg::res_t   res;
	logic            res_valid, res_ready;

	// divider link
	logic                         div_start, div_done;
	logic [boc_pkg::POS_BITS-1:0] div_dividend, div_quo;
	logic [DIM_BITS-1:0]          div_divisor, div_rem;

	// output register
	logic                m_valid_q;
	boc_pkg::res_t       m_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_rank_q      <= boc_pkg::RANK_RESET;
			in_rank_q       <= boc_pkg::RANK_RESET;
			out_dims_low_q  <= boc_pkg::DIMS_RESET;
			out_dims_high_q <= boc_pkg::DIMS_RESET;
			in_dims_low_q   <= boc_pkg::DIMS_RESET;
			in_dims_high_q  <= boc_pkg::DIMS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				boc_pkg::REG_OUT_RANK:      out_rank_q      <= cfg_data[3:0];
				boc_pkg::REG_IN_RANK:       in_rank_q       <= cfg_data[3:0];
				boc_pkg::REG_OUT_DIMS_LOW:  out_dims_low_q  <= cfg_data;
				boc_pkg::REG_OUT_DIMS_HIGH: out_dims_high_q <= cfg_data;
				boc_pkg::REG_IN_DIMS_LOW:   in_dims_low_q   <= cfg_data;
				boc_pkg::REG_IN_DIMS_HIGH:  in_dims_high_q  <= cfg_data;
				default: ; // unused indexes are ignored
			endcase
		end
	end

	// dimension k sits in 16-bit slot k of the high:low pair
	assign shape.out_rank = out_rank_q;
	assign shape.in_rank  = in_rank_q;
	assign shape.out_dims = {out_dims_high_q, out_dims_low_q};
	assign shape.in_dims  = {in_dims_high_q, in_dims_low_q};

	boc_ctrl #(
		.MAX_DIMS (MAX_DIMS),
		.DIM_BITS (DIM_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.shape        (shape),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_pos       (s_axis_tdata[boc_pkg::POS_BITS-1:0]),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quo      (div_quo),
		.div_rem      (div_rem)
	);

	boc_div #(
		.DIM_BITS (DIM_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// output register frees the sequencer while a result waits downstream
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_valid_q <= 1'b0;
		else if (res_valid && res_ready)
			m_valid_q <= 1'b1;
		else if (m_axis_tready)
			m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			m_res_q <= res;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {1'b0, m_res_q.in_position};
	assign m_axis_tuser  = m_res_q.shape_error;

	// an accepted item leaves the block busy in the cycle after it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while previous item still in work");

	// a finished result is held in the sequencer until the output register takes it
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("pending result dropped or changed");

	// the sequencer never offers a result while it takes a new item
	a_res_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !s_axis_tready)
		else $error("result pending while block reports idle");

	// the divider only reports done when the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> !s_axis_tready && !res_valid && !div_start)
		else $error("divider done outside a division");

endmodule

`default_nettype wire
